[src/efwa_pkg.sv]
`default_nettype none
package efwa_pkg;

  localparam int Workers = 16;
  localparam int IdxW    = $clog2(Workers);
  localparam int TimeW   = 48;
  localparam int DurW    = 30;
  localparam int CountW  = 5;
  localparam int InW     = 32;
  localparam int OutW    = 56;

  localparam logic [TimeW-1:0]  TimeMax    = {TimeW{1'b1}};
  localparam logic [CountW-1:0] CountReset = CountW'(Workers);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic scan_end;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

[src/earliest_free_worker_assigner.sv]
// Assigns each job word (duration in s_axis_tdata) to the active worker with the
// earliest next-free time, lowest worker number on ties, and returns the worker
// and its start time on the master side while that worker's free time advances
// by the duration, saturating at 2^48-1. All free times clear to zero at reset;
// cfg_wr_data sets how many workers take part (0 acts as 1, above 16 as 16).
// One job is in flight at a time: the next job is accepted only after the
// scan, which compares one stored free time per cycle over the active workers,
// and the update, which waits for a free output register. A finished result waits in
// an output register, so a new job is accepted while it is still untaken.
`default_nettype none
module earliest_free_worker_assigner (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           cfg_wr_en,
  input  wire [efwa_pkg::CountW-1:0]    cfg_wr_data,
  input  wire                           s_axis_tvalid,
  output logic                          s_axis_tready,
  input  wire [efwa_pkg::InW-1:0]       s_axis_tdata,  // [29:0] duration
  output logic                          m_axis_tvalid,
  input  wire                           m_axis_tready,
  output logic [efwa_pkg::OutW-1:0]     m_axis_tdata   // [3:0] worker, [51:4] start_time
);
  import efwa_pkg::*;

  cmd_t             cmd;
  status_t          status;
  state_t           state;
  logic [IdxW-1:0]  worker;
  logic [TimeW-1:0] start_time;

  efwa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .status    (status),
    .cmd       (cmd),
    .state_out (state)
  );

  efwa_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .duration    (s_axis_tdata[DurW-1:0]),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_worker  (worker),
    .out_start   (start_time)
  );

  assign m_axis_tdata = {(OutW - IdxW - TimeW)'(0), start_time, worker};

  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("accepted a second job while one is in flight");

  assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == ST_UPDATE))
    else $error("result raised outside the update step");

  assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !m_axis_tvalid || m_axis_tready)
    else $error("result committed over an untaken word");

endmodule
`default_nettype wire

[src/efwa_ctrl.sv]
`default_nettype none
module efwa_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_ready,
  input  efwa_pkg::status_t status,
  output efwa_pkg::cmd_t    cmd,
  output efwa_pkg::state_t  state_out
);
  import efwa_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
        if (status.scan_end) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign state_out = state;

endmodule
`default_nettype wire

[src/efwa_dp.sv]
`default_nettype none
module efwa_dp (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         cfg_wr_en,
  input  wire [efwa_pkg::CountW-1:0]  cfg_wr_data,
  input  wire [efwa_pkg::DurW-1:0]    duration,
  input  efwa_pkg::cmd_t              cmd,
  output efwa_pkg::status_t           status,
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic [efwa_pkg::IdxW-1:0]   out_worker,
  output logic [efwa_pkg::TimeW-1:0]  out_start
);
  import efwa_pkg::*;

  logic [CountW-1:0] thread_count;
  logic [TimeW-1:0]  free_time [Workers];
  logic [DurW-1:0]   dur;
  logic [IdxW-1:0]   idx;
  logic [IdxW-1:0]   best;
  logic [TimeW-1:0]  best_time;
  logic [IdxW-1:0]   last;
  logic [TimeW:0]    sum;
  logic [TimeW-1:0]  next_time;
  logic [TimeW-1:0]  cand;

  always_comb begin
    if (thread_count == '0) begin
      last = '0;
    end else if (thread_count > CountW'(Workers)) begin
      last = IdxW'(Workers - 1);
    end else begin
      last = IdxW'(thread_count - CountW'(1));
    end
  end

  assign cand      = free_time[idx];
  assign sum       = {1'b0, best_time} + (TimeW+1)'(dur);
  assign next_time = sum[TimeW] ? TimeMax : sum[TimeW-1:0];

  assign status.scan_end = (last == '0) || (idx == last);
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      thread_count <= CountReset;
    end else if (cfg_wr_en) begin
      thread_count <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < Workers; i++) begin
        free_time[i] <= '0;
      end
    end else if (cmd.commit) begin
      free_time[best] <= next_time;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dur       <= duration;
      best      <= '0;
      best_time <= free_time[0];
      idx       <= IdxW'(1);
    end else if (cmd.step && last != '0) begin
      if (cand < best_time) begin
        best      <= idx;
        best_time <= cand;
      end
      idx <= idx + IdxW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_worker <= best;
      out_start  <= best_time;
    end
  end

endmodule
`default_nettype wire
